@@ hw/rtl/msp_pkg.sv @@
// Shared types, codes and the register body length table of the meter register stream parser.
// Depends on nothing; every other file of the block imports it.
package msp_pkg;

   // Parser phases.
   localparam logic [2:0] PH_FILLER = 3'd0;
   localparam logic [2:0] PH_STATUS = 3'd1;
   localparam logic [2:0] PH_REG    = 3'd2;
   localparam logic [2:0] PH_BODY   = 3'd3;
   localparam logic [2:0] PH_TOTAL  = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;
   localparam logic [2:0] PH_ERROR  = 3'd6;

   // Outcome codes reported with the last byte of a payload.
   localparam logic [2:0] OUT_OK        = 3'd0;
   localparam logic [2:0] OUT_FILLER    = 3'd1;
   localparam logic [2:0] OUT_SHORT     = 3'd2;
   localparam logic [2:0] OUT_UNKNOWN   = 3'd3;
   localparam logic [2:0] OUT_TRUNCATED = 3'd4;
   localparam logic [2:0] OUT_NOREG     = 3'd5;
   localparam logic [2:0] OUT_NOTOTAL   = 3'd6;

   // Special byte values.
   localparam logic [7:0] FILLER_CODE  = 8'h2F;
   localparam logic [7:0] END_CODE     = 8'hFF;
   localparam logic [7:0] TOTAL_CODE_A = 8'h10;
   localparam logic [7:0] TOTAL_CODE_B = 8'hA1;

   // The total register body is a little-endian 32-bit word.
   localparam int TOTAL_BYTES = 4;
   localparam int CAP_W       = 2;
   localparam int BODY_W      = 6;   // longest body is 1 + 12 * 4 = 49 bytes

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } stage_type;

   // Body length of a register code; zero marks a code that is not known.
   function automatic logic [BODY_W-1:0] body_length(input logic [7:0] code);
      logic [7:0] offset;
      offset = 8'(code - 8'h6F);
      case (code)
         8'h00, 8'h10, 8'hA1, 8'h42, 8'hA0, 8'hA4, 8'hF0: body_length = 6'd4;
         8'h01, 8'h44, 8'hA6:                             body_length = 6'd3;
         8'h11, 8'h41, 8'h43, 8'hA7, 8'hA8, 8'hAA, 8'hAB,
         8'hAC, 8'hAD, 8'hB4:                             body_length = 6'd2;
         8'h40, 8'h8B, 8'h8C:                             body_length = 6'd6;
         8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h86, 8'h87: body_length = 6'd10;
         8'h85, 8'h88, 8'h8F:                             body_length = 6'd11;
         8'h8A:                                           body_length = 6'd9;
         8'h8E, 8'hA3:                                    body_length = 6'd7;
         8'hA2, 8'hA5, 8'hA9, 8'hAF:                      body_length = 6'd1;
         8'hB0:                                           body_length = 6'd5;
         8'hB1, 8'hB3:                                    body_length = 6'd8;
         8'hB2, 8'hB5:                                    body_length = 6'd16;
         default: begin
            if (code inside {[8'h71:8'h7B]}) begin
               // The offset is 2 to 12, so offset * 4 + 1 fits six bits.
               body_length = {offset[3:0], 2'b01};
            end else if (code inside {[8'hB6:8'hC7], 8'hD0, 8'hD3}) begin
               body_length = 6'd3;
            end else begin
               body_length = 6'd0;
            end
         end
      endcase
   endfunction

endpackage

@@ hw/rtl/msp_input_stage.sv @@
// Input register of the meter register stream parser: holds one byte transaction.
// Depends on msp_pkg for the stage structure.
module msp_input_stage
   import msp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       take,
   output stage_type  stage
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       load;

   // The register is free when empty or when its byte moves on in this cycle.
   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;
   assign stage.last  = last_ff;

endmodule

@@ hw/rtl/msp_parse_core.sv @@
// Parser state and its one-byte update, plus the outcome computed on the last byte.
// Depends on msp_pkg for phase and outcome codes and the body length table.
module msp_parse_core
   import msp_pkg::*;
#(
   parameter int STATUS_BYTES = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  stage_type                 stage,
   output logic [2:0]                outcome,
   output logic [31:0]               total_volume,
   output logic [8*STATUS_BYTES-1:0] status_block
);

   localparam int CNT_W = (STATUS_BYTES > 1) ? $clog2(STATUS_BYTES) : 1;
   localparam logic [CNT_W-1:0] LAST_HDR = CNT_W'(STATUS_BYTES - 1);
   localparam logic [CAP_W-1:0] LAST_CAP = CAP_W'(TOTAL_BYTES - 1);

   logic [2:0]                phase_ff, phase_in;
   logic [BODY_W-1:0]         body_remaining_ff, body_remaining_in;
   logic [CNT_W-1:0]          header_count_ff, header_count_in;
   logic [CAP_W-1:0]          capture_index_ff, capture_index_in;
   logic [31:0]               total_shift_ff, total_shift_in;
   logic [8*STATUS_BYTES-1:0] status_shift_ff, status_shift_in;
   logic                      total_seen_ff, total_seen_in;
   logic                      register_seen_ff, register_seen_in;
   logic [BODY_W-1:0]         code_len;
   logic [2:0]                outcome_code;

   assign code_len = body_length(stage.data);

   always_comb begin
      phase_in          = phase_ff;
      body_remaining_in = body_remaining_ff;
      header_count_in   = header_count_ff;
      capture_index_in  = capture_index_ff;
      total_shift_in    = total_shift_ff;
      status_shift_in   = status_shift_ff;
      total_seen_in     = total_seen_ff;
      register_seen_in  = register_seen_ff;

      case (phase_ff)
         PH_FILLER: begin
            // The first byte that is not filler is the marker and is dropped.
            if (stage.data != FILLER_CODE) begin
               phase_in = PH_STATUS;
            end
         end
         PH_STATUS: begin
            status_shift_in[8*header_count_ff +: 8] = stage.data;
            if (header_count_ff == LAST_HDR) begin
               header_count_in = '0;
               phase_in        = PH_REG;
            end else begin
               header_count_in = header_count_ff + 1'b1;
            end
         end
         PH_REG: begin
            if (stage.data == END_CODE) begin
               phase_in = PH_DONE;
            end else if (code_len == '0) begin
               phase_in = PH_ERROR;
            end else begin
               register_seen_in  = 1'b1;
               body_remaining_in = code_len;
               if (!total_seen_ff &&
                   (stage.data == TOTAL_CODE_A || stage.data == TOTAL_CODE_B)) begin
                  capture_index_in = '0;
                  phase_in         = PH_TOTAL;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_TOTAL: begin
            total_shift_in[8*capture_index_ff +: 8] = stage.data;
            capture_index_in  = capture_index_ff + 1'b1;
            if (capture_index_ff == LAST_CAP) begin
               total_seen_in = 1'b1;
            end
            body_remaining_in = body_remaining_ff - 1'b1;
            if (body_remaining_ff == BODY_W'(1)) begin
               phase_in = PH_REG;
            end
         end
         PH_BODY: begin
            if (body_remaining_ff != '0) begin
               body_remaining_in = body_remaining_ff - 1'b1;
            end
            if (body_remaining_ff <= BODY_W'(1)) begin
               phase_in = PH_REG;
            end
         end
         default: begin
         end
      endcase

      // The outcome looks at the state as it stands after this byte.
      if (phase_in == PH_ERROR) begin
         outcome_code = OUT_UNKNOWN;
      end else if (phase_in == PH_FILLER) begin
         outcome_code = OUT_FILLER;
      end else if (phase_in == PH_STATUS) begin
         outcome_code = OUT_SHORT;
      end else if (phase_in == PH_BODY || phase_in == PH_TOTAL) begin
         outcome_code = OUT_TRUNCATED;
      end else if (!register_seen_in) begin
         outcome_code = OUT_NOREG;
      end else if (!total_seen_in) begin
         outcome_code = OUT_NOTOTAL;
      end else begin
         outcome_code = OUT_OK;
      end

      // A finished payload puts the parser back into its reset state.
      if (stage.last) begin
         phase_in          = PH_FILLER;
         body_remaining_in = '0;
         header_count_in   = '0;
         capture_index_in  = '0;
         total_seen_in     = 1'b0;
         register_seen_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_FILLER;
         body_remaining_ff <= '0;
         header_count_ff   <= '0;
         capture_index_ff  <= '0;
         total_seen_ff     <= 1'b0;
         register_seen_ff  <= 1'b0;
      end else if (step) begin
         phase_ff          <= phase_in;
         body_remaining_ff <= body_remaining_in;
         header_count_ff   <= header_count_in;
         capture_index_ff  <= capture_index_in;
         total_seen_ff     <= total_seen_in;
         register_seen_ff  <= register_seen_in;
      end
   end

   // Every captured byte is overwritten before it can be reported.
   always_ff @(posedge clock) begin
      if (step) begin
         total_shift_ff  <= total_shift_in;
         status_shift_ff <= status_shift_in;
      end
   end

   assign outcome      = outcome_code;
   assign total_volume = (outcome_code == OUT_OK) ? total_shift_in : '0;
   assign status_block = (outcome_code == OUT_OK) ? status_shift_in : '0;

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      step && stage.last |=> phase_ff == PH_FILLER && !register_seen_ff && !total_seen_ff)
      else $error("parser did not return to the filler phase after a last byte");

   a_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY || phase_ff == PH_TOTAL) |-> body_remaining_ff != '0)
      else $error("body phase entered with no body bytes remaining");

   a_total_once: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TOTAL |-> !total_seen_ff && register_seen_ff)
      else $error("total capture running after the total was already taken");

endmodule

@@ hw/rtl/meter_register_stream_parser.sv @@
// A result is formed as its last byte leaves the input register and is held in the output register.
// Throughput: one byte transaction per cycle; a last byte waits in the input register
// only while the output register still holds an earlier result under stall.
// Reset (synchronous, active high) returns the parser to the filler phase and empties
// both the input register and the output register.
// Depends on msp_pkg, msp_input_stage and msp_parse_core.
module meter_register_stream_parser
   import msp_pkg::*;
#(
   parameter int STATUS_BYTES = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   // Payload byte channel.
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_last_byte,
   // Result channel: one transaction per payload.
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_outcome,
   output logic [31:0]               rsp_total_volume,
   output logic [8*STATUS_BYTES-1:0] rsp_status_block
);

   stage_type                 stage;
   logic                      take;
   logic                      result_load;
   logic [2:0]                core_outcome;
   logic [31:0]               core_total;
   logic [8*STATUS_BYTES-1:0] core_status;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [2:0]                rsp_outcome_ff;
   logic [31:0]               rsp_total_ff;
   logic [8*STATUS_BYTES-1:0] rsp_status_ff;

   // The byte in the input register is parsed in the cycle it moves on. Only a last
   // byte produces a result, so only a last byte needs the output register to be free
   // (empty, or emptied by the consumer in this same cycle).
   assign take = stage.valid &&
                 (!stage.last || !rsp_valid_ff || !rsp_stall);
   assign result_load = take && stage.last;

   msp_input_stage u_input (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .take          (take),
      .stage         (stage)
   );

   // The parser state advances once per byte; its outcome is formed from the state
   // as it stands after the byte and is captured here only for a last byte.
   msp_parse_core #(
      .STATUS_BYTES (STATUS_BYTES)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (take),
      .stage        (stage),
      .outcome      (core_outcome),
      .total_volume (core_total),
      .status_block (core_status)
   );

   // Output register: holds a result until the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_outcome_ff <= core_outcome;
         rsp_total_ff   <= core_total;
         rsp_status_ff  <= core_status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = rsp_outcome_ff;
   assign rsp_total_volume = rsp_total_ff;
   assign rsp_status_block = rsp_status_ff;

   // A result under stall must never be overwritten by the next payload's result.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !result_load)
      else $error("result overwritten while the consumer stalls");

   // A last byte held back can only be waiting for the output register.
   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      stage.valid && !take |-> stage.last && rsp_valid_ff && rsp_stall)
      else $error("input register held without a full output register");

   // A reported failure always carries zero total and status fields.
   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      result_load && core_outcome != OUT_OK |-> core_total == '0 && core_status == '0)
      else $error("failed payload reported non-zero fields");

endmodule
